// File: rtl/rmsp_pkg.sv
package rmsp_pkg;

  localparam int DATA_W  = 32;
  localparam int DECAY_W = 16;
  localparam int RATE_W  = 24;
  localparam int NUM_W   = DATA_W + RATE_W;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 24;
  // Quotient bits kept by the divider; anything larger saturates the weight anyway.
  localparam int QUO_W   = DATA_W + 1;

  localparam logic [CFG_IDX_W-1:0] REG_DECAY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATE  = 2'd1;

  localparam logic [DECAY_W-1:0] DECAY_RST = 16'd64881;
  localparam logic [RATE_W-1:0]  RATE_RST  = 24'd1678;

  // Pipeline control shared by all stages of one shared stall domain.
  typedef struct packed {
    logic adv;
    logic vld;
  } rmsp_ctl_t;

endpackage

// File: rtl/rmsp_sqrt.sv
module rmsp_sqrt #(
  parameter int XW = 56,
  parameter int RW = 28,
  parameter int SW = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rmsp_pkg::rmsp_ctl_t  ctl_i,
  input  logic [XW-1:0]        x_i,
  input  logic [SW-1:0]        side_i,
  output logic                 vld_o,
  output logic [RW-1:0]        root_o,
  output logic [SW-1:0]        side_o
);
  import rmsp_pkg::*;

  logic [XW-1:0] rem_w  [RW+1];
  logic [RW-1:0] root_w [RW+1];
  logic [SW-1:0] side_w [RW+1];
  logic          vld_w  [RW+1];

  assign rem_w[0]  = x_i;
  assign root_w[0] = '0;
  assign side_w[0] = side_i;
  assign vld_w[0]  = ctl_i.vld;

  // One root bit per stage, most significant first.
  for (genvar k = 0; k < RW; k++) begin : g_stage
    localparam int B = RW - 1 - k;
    logic [XW:0]   trial;
    logic          take;
    logic [XW-1:0] rem_d, rem_q;
    logic [RW-1:0] root_d, root_q;
    logic [SW-1:0] side_q;
    logic          vld_q;

    assign trial  = ((XW+1)'(root_w[k]) << (B + 1)) + ((XW+1)'(1) << (2 * B));
    assign take   = {1'b0, rem_w[k]} >= trial;
    assign rem_d  = take ? rem_w[k] - trial[XW-1:0] : rem_w[k];
    assign root_d = take ? (root_w[k] | (RW'(1) << B)) : root_w[k];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (ctl_i.adv) begin
        vld_q <= vld_w[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.adv) begin
        rem_q  <= rem_d;
        root_q <= root_d;
        side_q <= side_w[k];
      end
    end

    assign rem_w[k+1]  = rem_q;
    assign root_w[k+1] = root_q;
    assign side_w[k+1] = side_q;
    assign vld_w[k+1]  = vld_q;
  end

  assign vld_o  = vld_w[RW];
  assign root_o = root_w[RW];
  assign side_o = side_w[RW];

endmodule

// File: rtl/rmsp_div.sv
module rmsp_div #(
  parameter int NW = 80,
  parameter int DW = 53,
  parameter int SW = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rmsp_pkg::rmsp_ctl_t         ctl_i,
  input  logic [NW-1:0]               n_i,
  input  logic [DW-1:0]               d_i,
  input  logic [SW-1:0]               side_i,
  output logic                        vld_o,
  output logic [rmsp_pkg::QUO_W-1:0]  q_o,
  output logic                        ovf_o,
  output logic [SW-1:0]               side_o
);
  import rmsp_pkg::*;

  localparam int RMW = DW + QUO_W;
  localparam int CW  = ((NW > RMW) ? NW : RMW) + 1;

  logic [RMW-1:0]   rem_w  [QUO_W+1];
  logic [DW-1:0]    d_w    [QUO_W+1];
  logic [QUO_W-1:0] q_w    [QUO_W+1];
  logic             ovf_w  [QUO_W+1];
  logic [SW-1:0]    side_w [QUO_W+1];
  logic             vld_w  [QUO_W+1];

  // Entry stage: a quotient that does not fit in QUO_W bits is flagged here,
  // otherwise the dividend fits in the remainder register.
  logic          ovf_d;
  logic [RMW-1:0] rem0_q;
  logic [DW-1:0]  d0_q;
  logic [SW-1:0]  side0_q;
  logic           ovf0_q, vld0_q;

  assign ovf_d = CW'(n_i) >= (CW'(d_i) << QUO_W);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
    end else if (ctl_i.adv) begin
      vld0_q <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv) begin
      rem0_q  <= RMW'(n_i);
      d0_q    <= d_i;
      ovf0_q  <= ovf_d;
      side0_q <= side_i;
    end
  end

  assign rem_w[0]  = rem0_q;
  assign d_w[0]    = d0_q;
  assign q_w[0]    = '0;
  assign ovf_w[0]  = ovf0_q;
  assign side_w[0] = side0_q;
  assign vld_w[0]  = vld0_q;

  // Restoring division, one quotient bit per stage.
  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    localparam int B = QUO_W - 1 - k;
    logic [RMW-1:0]   dk;
    logic             take;
    logic [RMW-1:0]   rem_q;
    logic [DW-1:0]    d_q;
    logic [QUO_W-1:0] q_q;
    logic             ovf_q, vld_q;
    logic [SW-1:0]    side_q;

    assign dk   = RMW'(d_w[k]) << B;
    assign take = rem_w[k] >= dk;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (ctl_i.adv) begin
        vld_q <= vld_w[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.adv) begin
        rem_q  <= take ? rem_w[k] - dk : rem_w[k];
        q_q    <= take ? (q_w[k] | (QUO_W'(1) << B)) : q_w[k];
        d_q    <= d_w[k];
        ovf_q  <= ovf_w[k];
        side_q <= side_w[k];
      end
    end

    assign rem_w[k+1]  = rem_q;
    assign d_w[k+1]    = d_q;
    assign q_w[k+1]    = q_q;
    assign ovf_w[k+1]  = ovf_q;
    assign side_w[k+1] = side_q;
    assign vld_w[k+1]  = vld_q;
  end

  assign vld_o  = vld_w[QUO_W];
  assign q_o    = q_w[QUO_W];
  assign ovf_o  = ovf_w[QUO_W];
  assign side_o = side_w[QUO_W];

endmodule

// File: rtl/rmsprop_weight_update.sv
// An accepted input word passes through stages 1 to 3, the RW square-root stages
// (RW = (32 + FRAC_BITS + 1) / 2), the denominator stage, the divider's entry and
// quotient stages and the output stage. Throughput is one word per cycle; the whole
// pipeline advances together and holds while the output word waits.
// Reset (rst_ni low, asynchronous) empties the pipeline and loads the default
// decay rate 0.99 and learning rate 0.0001.
module rmsprop_weight_update #(
  parameter int FRAC_BITS = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rmsp_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [rmsp_pkg::CFG_DAT_W-1:0]    cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [rmsp_pkg::DATA_W-1:0] weight_in_i,
  input  logic signed [rmsp_pkg::DATA_W-1:0] gradient_i,
  input  logic [rmsp_pkg::DATA_W-1:0]       mean_square_in_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [rmsp_pkg::DATA_W-1:0] weight_out_o,
  output logic [rmsp_pkg::DATA_W-1:0]       mean_square_out_o,
  output logic                              saturated_o
);
  import rmsp_pkg::*;

  // Square-root operand is the new mean square scaled up by FRAC_BITS, padded
  // to an even width so that each stage resolves exactly one root bit.
  localparam int XW  = DATA_W + FRAC_BITS + (FRAC_BITS % 2);
  localparam int RW  = XW / 2;
  localparam int DNW = RW + 1;
  localparam int DW  = DNW + RATE_W;
  localparam int NW  = NUM_W + FRAC_BITS;
  // eps = round(1e-5 * 2^FRAC_BITS), never below one.
  localparam logic [63:0] EPS_R = ((64'd1 << FRAC_BITS) + 64'd50000) / 64'd100000;
  localparam logic [63:0] EPS   = (EPS_R == 64'd0) ? 64'd1 : EPS_R;
  localparam int SQ_SW  = NUM_W + DATA_W + 1 + DATA_W + 1;
  localparam int DIV_SW = DATA_W + 1 + DATA_W + 1;

  // Configuration registers.
  logic [DECAY_W-1:0] decay_q;
  logic [RATE_W-1:0]  rate_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decay_q <= DECAY_RST;
      rate_q  <= RATE_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_DECAY) begin
        decay_q <= cfg_data_i[DECAY_W-1:0];
      end else if (cfg_idx_i == REG_RATE) begin
        rate_q <= cfg_data_i[RATE_W-1:0];
      end
    end
  end

  // The whole pipeline moves as one; it stalls only when the output word is
  // held by the consumer.
  logic      adv;
  logic      out_vld_q;
  rmsp_ctl_t sq_ctl, div_ctl;

  assign adv        = !out_vld_q || out_ready_i;
  assign in_ready_o = adv;

  // Stage 1: gradient magnitude and its square.
  logic [DATA_W-1:0]   gmag_d;
  logic                s1_vld_q, s1_neg_q;
  logic signed [DATA_W-1:0] s1_w_q;
  logic [DATA_W-1:0]   s1_gmag_q, s1_ms_q;
  logic [2*DATA_W-1:0] s1_sq_q;

  assign gmag_d = gradient_i[DATA_W-1] ? DATA_W'(-gradient_i) : DATA_W'(gradient_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_w_q    <= weight_in_i;
      s1_neg_q  <= gradient_i[DATA_W-1];
      s1_gmag_q <= gmag_d;
      s1_ms_q   <= mean_square_in_i;
      s1_sq_q   <= (2*DATA_W)'(gmag_d) * (2*DATA_W)'(gmag_d);
    end
  end

  // Stage 2: round the square, then the two mean-square products and the
  // unscaled step numerator |g| * rate.
  logic [2*DATA_W:0] sqh, g2f;
  logic              big_d;
  logic              s2_vld_q, s2_neg_q, s2_big_q;
  logic signed [DATA_W-1:0] s2_w_q;
  logic [47:0]       s2_pa_q;
  logic [64:0]       s2_pb_q;
  logic [NUM_W-1:0]  s2_num_q;

  assign sqh   = {1'b0, s1_sq_q} + ((2*DATA_W+1)'(1) << (FRAC_BITS - 1));
  assign g2f   = sqh >> FRAC_BITS;
  assign big_d = |(g2f >> 48);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (adv) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_w_q   <= s1_w_q;
      s2_neg_q <= s1_neg_q;
      s2_big_q <= big_d;
      s2_pa_q  <= 48'(decay_q) * 48'(s1_ms_q);
      s2_pb_q  <= 65'(17'(17'h10000 - 17'(decay_q))) * 65'(g2f[47:0]);
      s2_num_q <= NUM_W'(s1_gmag_q) * NUM_W'(rate_q);
    end
  end

  // Stage 3: new mean square with rounding and saturation.
  logic [65:0]       msum;
  logic              ms_sat;
  logic              s3_vld_q, s3_neg_q, s3_sat_q;
  logic signed [DATA_W-1:0] s3_w_q;
  logic [DATA_W-1:0] s3_ms_q;
  logic [NUM_W-1:0]  s3_num_q;

  assign msum   = 66'(s2_pa_q) + 66'(s2_pb_q) + 66'd32768;
  assign ms_sat = s2_big_q || (msum[65:48] != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (adv) begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_w_q   <= s2_w_q;
      s3_neg_q <= s2_neg_q;
      s3_sat_q <= ms_sat;
      s3_ms_q  <= ms_sat ? '1 : msum[47:16];
      s3_num_q <= s2_num_q;
    end
  end

  // Square root of the new mean square, one bit per stage.
  logic              sq_vld;
  logic [RW-1:0]     root;
  logic [SQ_SW-1:0]  sq_side;

  assign sq_ctl = '{adv: adv, vld: s3_vld_q};

  rmsp_sqrt #(
    .XW (XW),
    .RW (RW),
    .SW (SQ_SW)
  ) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (sq_ctl),
    .x_i    (XW'(s3_ms_q) << FRAC_BITS),
    .side_i ({s3_num_q, s3_w_q, s3_neg_q, s3_ms_q, s3_sat_q}),
    .vld_o  (sq_vld),
    .root_o (root),
    .side_o (sq_side)
  );

  // Denominator stage: add eps and line up dividend and divisor.
  logic [NUM_W-1:0]  sq_num;
  logic [DNW-1:0]    denom;
  logic              dn_vld_q;
  logic [NW-1:0]     dn_n_q;
  logic [DW-1:0]     dn_d_q;
  logic [DIV_SW-1:0] dn_side_q;

  assign sq_num = sq_side[SQ_SW-1 -: NUM_W];
  assign denom  = DNW'(root) + DNW'(EPS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dn_vld_q <= 1'b0;
    end else if (adv) begin
      dn_vld_q <= sq_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dn_n_q    <= NW'(sq_num) << FRAC_BITS;
      dn_d_q    <= {denom, RATE_W'(0)};
      dn_side_q <= sq_side[DIV_SW-1:0];
    end
  end

  // Step magnitude by long division, truncated toward zero.
  logic              dv_vld, dv_ovf;
  logic [QUO_W-1:0]  dv_q;
  logic [DIV_SW-1:0] dv_side;

  assign div_ctl = '{adv: adv, vld: dn_vld_q};

  rmsp_div #(
    .NW (NW),
    .DW (DW),
    .SW (DIV_SW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (div_ctl),
    .n_i    (dn_n_q),
    .d_i    (dn_d_q),
    .side_i (dn_side_q),
    .vld_o  (dv_vld),
    .q_o    (dv_q),
    .ovf_o  (dv_ovf),
    .side_o (dv_side)
  );

  // Output stage: apply the step with the sign of the gradient and clamp the
  // weight to the signed 32-bit range.
  logic signed [DATA_W-1:0] f_w;
  logic                     f_neg, f_sat;
  logic [DATA_W-1:0]        f_ms;
  logic [QUO_W-1:0]         step;
  logic signed [DATA_W+2:0] wx, qx, wn;
  logic                     w_hi, w_lo;
  logic signed [DATA_W-1:0] w_out_q;
  logic [DATA_W-1:0]        ms_out_q;
  logic                     sat_out_q;

  assign {f_w, f_neg, f_ms, f_sat} = dv_side;
  assign step = dv_ovf ? '1 : dv_q;
  assign wx   = (DATA_W+3)'(f_w);
  assign qx   = signed'({2'b00, step});
  assign wn   = f_neg ? wx - qx : wx + qx;
  assign w_hi = wn > (DATA_W+3)'(32'sh7FFFFFFF);
  assign w_lo = wn < -((DATA_W+3)'(64'sh80000000));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      w_out_q   <= w_hi ? 32'sh7FFFFFFF : (w_lo ? 32'sh80000000 : wn[DATA_W-1:0]);
      ms_out_q  <= f_ms;
      sat_out_q <= f_sat || w_hi || w_lo;
    end
  end

  assign out_valid_o       = out_vld_q;
  assign weight_out_o      = w_out_q;
  assign mean_square_out_o = ms_out_q;
  assign saturated_o       = sat_out_q;

endmodule

// File: rtl/rmsp_chk.sv
module rmsp_chk (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rmsp_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [rmsp_pkg::CFG_DAT_W-1:0]    cfg_data_i,
  input  logic                              in_valid_i,
  input  logic                              in_ready_o,
  input  logic signed [rmsp_pkg::DATA_W-1:0] weight_in_i,
  input  logic signed [rmsp_pkg::DATA_W-1:0] gradient_i,
  input  logic [rmsp_pkg::DATA_W-1:0]       mean_square_in_i,
  input  logic                              out_valid_o,
  input  logic                              out_ready_i,
  input  logic signed [rmsp_pkg::DATA_W-1:0] weight_out_o,
  input  logic [rmsp_pkg::DATA_W-1:0]       mean_square_out_o,
  input  logic                              saturated_o
);
  import rmsp_pkg::*;

  // No word leaves during reset.
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("output word valid during reset");

  // A flagged word whose mean square did not clip must carry a clipped weight.
  a_sat_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && saturated_o && (mean_square_out_o != '1)) |->
    ((weight_out_o == 32'sh7FFFFFFF) || (weight_out_o == 32'sh80000000)))
    else $error("saturation flag without a clipped result");

  // The pipeline only stalls when the output word is held.
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with an empty output");

  // A held output word keeps its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
    (out_valid_o && $stable(weight_out_o) && $stable(mean_square_out_o)))
    else $error("output word changed while stalled");

endmodule

bind rmsprop_weight_update rmsp_chk u_rmsp_chk (.*);
